// ===== rtl/u8d_pkg.sv =====
// u8d_pkg: shared types and constants for the UTF-8 decoder.
// No dependencies; used by the channel interfaces and the top level.

package u8d_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 3;

  localparam logic [CP_W-1:0] MAX_CP_RESET = 21'h10FFFF;

  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_PAT   = 8'h80;
  localparam logic [BYTE_W-1:0] ASCII_MAX  = 8'h7F;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_LEAD  = 3'd1,
    ST_BAD_CONT  = 3'd2,
    ST_TRUNCATED = 3'd3,
    ST_ABOVE_MAX = 3'd4
  } status_t;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CP_W-1:0]  cp_t;

endpackage

// ===== rtl/u8d_if.sv =====
// Valid/ready channel interfaces for the UTF-8 decoder: byte input,
// code point result and max_codepoint configuration write. Uses u8d_pkg.

interface u8d_in_if import u8d_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              end_of_string;

  modport source (output valid, data_byte, end_of_string, input ready);
  modport sink   (input valid, data_byte, end_of_string, output ready);
endinterface

interface u8d_out_if import u8d_pkg::*; ();
  logic    valid;
  logic    ready;
  cp_t     codepoint;
  status_t status;
  logic    last;

  modport source (output valid, codepoint, status, last, input ready);
  modport sink   (input valid, codepoint, status, last, output ready);
endinterface

interface u8d_cfg_if import u8d_pkg::*; ();
  logic valid;
  logic ready;
  cp_t  max_codepoint;

  modport source (output valid, max_codepoint, input ready);
  modport sink   (input valid, max_codepoint, output ready);
endinterface

// ===== rtl/utf8_to_codepoint_decoder.sv =====
// UTF-8 to code point decoder, top level.
// Depends on u8d_pkg and the channel interfaces in u8d_if.sv.
//
// One byte is taken per clock and its result, if any, appears in the output
// register on the next cycle; a new byte is accepted every cycle unless a
// held result is stalled by the sink. The whole decode step for a byte is one
// level of logic between the string state registers and the result register.
// A completed character in range gives its code point; the end byte always
// gives exactly one result with last set. The first error is reported at once
// and held; later bytes are silent until the end byte, which repeats it.
// max_codepoint may only be rewritten while the decoder is idle.

module utf8_to_codepoint_decoder
  import u8d_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  u8d_in_if.sink    in_ch,
  u8d_out_if.source out_ch,
  u8d_cfg_if.sink   cfg_ch
);

  cp_t     max_cp_r;
  cnt_t    exp_r, exp_nxt;
  cnt_t    seen_r, seen_nxt;
  cp_t     acc_r, acc_nxt;
  logic    err_r, err_nxt;
  status_t err_st_r, err_st_nxt;

  logic    out_valid_r;
  cp_t     out_cp_r, out_cp_nxt;
  status_t out_st_r, out_st_nxt;
  logic    out_last_r, out_last_nxt;
  logic    emit;

  logic    in_fire;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.codepoint = out_cp_r;
  assign out_ch.status    = out_st_r;
  assign out_ch.last      = out_last_r;

  always_comb begin
    logic [BYTE_W-1:0] b;
    logic              eos;
    logic              fin_req;
    cp_t               fin_cp;
    logic              err_req;
    status_t           err_code;
    cp_t               acc_shift;
    cnt_t              seen_inc;

    b         = in_ch.data_byte;
    eos       = in_ch.end_of_string;
    fin_req   = 1'b0;
    fin_cp    = '0;
    err_req   = 1'b0;
    err_code  = ST_OK;
    acc_shift = {acc_r[CP_W-7:0], b[5:0]};
    seen_inc  = seen_r + cnt_t'(1);

    exp_nxt      = exp_r;
    seen_nxt     = seen_r;
    acc_nxt      = acc_r;
    err_nxt      = err_r;
    err_st_nxt   = err_st_r;
    emit         = 1'b0;
    out_cp_nxt   = '0;
    out_st_nxt   = ST_OK;
    out_last_nxt = eos;

    if (err_r) begin
      if (eos) begin
        emit       = 1'b1;
        out_st_nxt = err_st_r;
      end
    end else if (exp_r == '0) begin
      if (b <= ASCII_MAX) begin
        fin_req = 1'b1;
        fin_cp  = cp_t'(b);
      end else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
        exp_nxt  = cnt_t'(2);
        acc_nxt  = cp_t'(b[4:0]);
        seen_nxt = cnt_t'(1);
        if (eos) begin
          err_req  = 1'b1;
          err_code = ST_TRUNCATED;
        end
      end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
        exp_nxt  = cnt_t'(3);
        acc_nxt  = cp_t'(b[3:0]);
        seen_nxt = cnt_t'(1);
        if (eos) begin
          err_req  = 1'b1;
          err_code = ST_TRUNCATED;
        end
      end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
        exp_nxt  = cnt_t'(4);
        acc_nxt  = cp_t'(b[2:0]);
        seen_nxt = cnt_t'(1);
        if (eos) begin
          err_req  = 1'b1;
          err_code = ST_TRUNCATED;
        end
      end else begin
        err_req  = 1'b1;
        err_code = ST_BAD_LEAD;
      end
    end else if ((b & CONT_MASK) != CONT_PAT) begin
      err_req  = 1'b1;
      err_code = ST_BAD_CONT;
    end else begin
      acc_nxt  = acc_shift;
      seen_nxt = seen_inc;
      if (seen_inc >= exp_r) begin
        fin_req = 1'b1;
        fin_cp  = acc_shift;
      end else if (eos) begin
        err_req  = 1'b1;
        err_code = ST_TRUNCATED;
      end
    end

    if (fin_req) begin
      exp_nxt  = '0;
      seen_nxt = '0;
      acc_nxt  = '0;
      if (fin_cp > max_cp_r) begin
        err_req  = 1'b1;
        err_code = ST_ABOVE_MAX;
      end else begin
        emit       = 1'b1;
        out_cp_nxt = fin_cp;
      end
    end

    if (err_req) begin
      exp_nxt    = '0;
      seen_nxt   = '0;
      acc_nxt    = '0;
      err_nxt    = 1'b1;
      err_st_nxt = err_code;
      emit       = 1'b1;
      out_cp_nxt = '0;
      out_st_nxt = err_code;
    end

    // end of string: back to a fresh string
    if (eos) begin
      exp_nxt    = '0;
      seen_nxt   = '0;
      acc_nxt    = '0;
      err_nxt    = 1'b0;
      err_st_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_cp_r    <= MAX_CP_RESET;
      exp_r       <= '0;
      seen_r      <= '0;
      acc_r       <= '0;
      err_r       <= 1'b0;
      err_st_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        max_cp_r <= cfg_ch.max_codepoint;
      end
      if (in_fire) begin
        exp_r    <= exp_nxt;
        seen_r   <= seen_nxt;
        acc_r    <= acc_nxt;
        err_r    <= err_nxt;
        err_st_r <= err_st_nxt;
      end
      if (in_fire && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_cp_r   <= out_cp_nxt;
      out_st_r   <= out_st_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  a_err_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_st_r != ST_OK) |-> out_cp_r == '0)
    else $error("error result with nonzero code point");

  a_err_idle_seq: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> (exp_r == '0) && (seen_r == '0) && (err_st_r != ST_OK))
    else $error("latched error with open sequence");

  a_seq_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (exp_r != '0) |-> (seen_r != '0) && (seen_r < exp_r) && !err_r)
    else $error("sequence counters out of range");

  a_eos_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.end_of_string |=> out_valid_r && out_last_r)
    else $error("end byte gave no last result");

  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.end_of_string |=> !err_r && (exp_r == '0))
    else $error("string state not cleared at end byte");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking testbench for utf8_to_codepoint_decoder, byte stream in, code points out.
// Uses u8d_pkg and the channel interfaces of u8d_if.sv; has its own decoder predictor.

module tb;
  import u8d_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef struct {
    logic [BYTE_W-1:0] b;
    logic              eos;
  } byte_item_t;

  typedef struct {
    cp_t     cp;
    status_t st;
    logic    last;
  } cp_result_t;

  logic clk = 1'b0;
  logic rst_n;

  u8d_in_if  in_ch();
  u8d_out_if out_ch();
  u8d_cfg_if cfg_ch();

  utf8_to_codepoint_decoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #10 clk = ~clk;

  byte_item_t        pending_bytes[$];
  cp_result_t        expected_cps[$];
  logic [BYTE_W-1:0] str_bytes[$];

  // decoder state as predicted
  cnt_t    dec_len   = '0;
  cnt_t    dec_seen  = '0;
  cp_t     dec_acc   = '0;
  logic    err_held  = 1'b0;
  status_t err_code  = ST_OK;
  cp_t     cp_limit  = MAX_CP_RESET;

  int   n_fail    = 0;
  int   cycle_cnt = 0;
  int   tx_wait   = 0;
  int   rx_wait   = 0;
  bit   idle_on   = 1'b0;
  bit   hold_go   = 1'b0;
  logic rx_hold   = 1'b0;

  byte_item_t next_item;
  cp_result_t want;

  function automatic int draw_gap();
    if (!idle_on || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic void decode_byte(logic [BYTE_W-1:0] b, logic eos);
    bit         emit;
    bit         chk_max;
    cp_result_t r;
    emit    = 1'b0;
    chk_max = 1'b0;
    r.cp    = '0;
    r.st    = ST_OK;
    r.last  = eos;
    if (err_held) begin
      emit = eos;
      r.st = err_code;
    end else if (dec_len == 0) begin
      if (b <= ASCII_MAX) begin
        emit    = 1'b1;
        chk_max = 1'b1;
        r.cp    = cp_t'(b);
      end else begin
        if ((b & LEAD2_MASK) == LEAD2_PAT) begin
          dec_len = 3'd2;
          dec_acc = cp_t'(b[4:0]);
        end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
          dec_len = 3'd3;
          dec_acc = cp_t'(b[3:0]);
        end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
          dec_len = 3'd4;
          dec_acc = cp_t'(b[2:0]);
        end else begin
          emit = 1'b1;
          r.st = ST_BAD_LEAD;
        end
        dec_seen = 3'd1;
        if (!emit && eos) begin
          emit = 1'b1;
          r.st = ST_TRUNCATED;
        end
      end
    end else if ((b & CONT_MASK) != CONT_PAT) begin
      emit = 1'b1;
      r.st = ST_BAD_CONT;
    end else begin
      dec_acc  = {dec_acc[CP_W-7:0], b[5:0]};
      dec_seen = dec_seen + 3'd1;
      if (dec_seen >= dec_len) begin
        emit    = 1'b1;
        chk_max = 1'b1;
        r.cp    = dec_acc;
      end else if (eos) begin
        emit = 1'b1;
        r.st = ST_TRUNCATED;
      end
    end
    if (chk_max && r.cp > cp_limit) begin
      r.cp = '0;
      r.st = ST_ABOVE_MAX;
    end
    if (emit) begin
      if (r.st != ST_OK && !err_held) begin
        err_held = 1'b1;
        err_code = r.st;
      end
      dec_len  = '0;
      dec_seen = '0;
      dec_acc  = '0;
      if (eos) begin
        err_held = 1'b0;
        err_code = ST_OK;
      end
      expected_cps.insert(expected_cps.size(), r);
    end
  endfunction

  // byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid         <= 1'b0;
      in_ch.data_byte     <= '0;
      in_ch.end_of_string <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(in_ch.data_byte, in_ch.end_of_string);
        tx_wait = draw_gap();
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_ch.valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          next_item = pending_bytes.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.data_byte     <= next_item.b;
          in_ch.end_of_string <= next_item.eos;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_ch.valid === 1'b1 && out_ch.ready) begin
        if (expected_cps.size() == 0) begin
          $error("unexpected item: codepoint %0h status %0d last %0b",
                 out_ch.codepoint, out_ch.status, out_ch.last);
          n_fail++;
        end else begin
          want = expected_cps.pop_front();
          if (out_ch.codepoint !== want.cp) begin
            $error("codepoint: expected %0h, got %0h", want.cp, out_ch.codepoint);
            n_fail++;
          end
          if (out_ch.status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, out_ch.status);
            n_fail++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_ch.last);
            n_fail++;
          end
        end
        rx_wait = draw_gap();
      end
      if (rx_hold) begin
        out_ch.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // long receiver stall so the decoder backs up into its input
  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void put_byte(logic [BYTE_W-1:0] v);
    str_bytes.insert(str_bytes.size(), v);
  endfunction

  task automatic add_char(cp_t cp, int len);
    case (len)
      1: put_byte({1'b0, cp[6:0]});
      2: begin
        put_byte({3'b110, cp[10:6]});
        put_byte({2'b10, cp[5:0]});
      end
      3: begin
        put_byte({4'b1110, cp[15:12]});
        put_byte({2'b10, cp[11:6]});
        put_byte({2'b10, cp[5:0]});
      end
      default: begin
        put_byte({5'b11110, cp[20:18]});
        put_byte({2'b10, cp[17:12]});
        put_byte({2'b10, cp[11:6]});
        put_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // moves the built string to the driver, end mark on its final byte
  task automatic queue_string();
    byte_item_t it;
    foreach (str_bytes[i]) begin
      it.b   = str_bytes[i];
      it.eos = (i == str_bytes.size() - 1);
      pending_bytes.insert(pending_bytes.size(), it);
    end
    str_bytes.delete();
  endtask

  task automatic gen_string();
    int  n_chars;
    int  len;
    cp_t cp;
    n_chars = $urandom_range(1, 6);
    repeat (n_chars) begin
      if ($urandom_range(0, 15) == 0) begin
        put_byte(8'($urandom));
      end else begin
        case ($urandom_range(0, 7))
          0: cp = cp_limit;
          1: cp = cp_limit + 1'b1;
          default: cp = '0;
        endcase
        if (cp != '0) begin
          len = (cp <= 21'h7F) ? 1 : (cp <= 21'h7FF) ? 2 : (cp <= 21'hFFFF) ? 3 : 4;
        end else begin
          len = $urandom_range(1, 4);
          case (len)
            1: cp = cp_t'($urandom_range(0, 21'h7F));
            2: cp = cp_t'($urandom_range(0, 21'h7FF));
            3: cp = cp_t'($urandom_range(0, 21'hFFFF));
            default: cp = cp_t'($urandom_range(0, 21'h1FFFFF));
          endcase
          if ($urandom_range(0, 3) == 0) cp = cp_t'($urandom_range(0, 21'h7F));
        end
        add_char(cp, len);
      end
    end
    if (str_bytes.size() > 1 && $urandom_range(0, 7) == 0) void'(str_bytes.pop_back());
    queue_string();
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_ch.valid || expected_cps.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(cp_t v);
    @(posedge clk);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.max_codepoint <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cp_limit = v;
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(cp_t lim, bit idle, int n_bytes, bit hold);
    write_limit(lim);
    idle_on = idle;
    while (pending_bytes.size() < n_bytes) gen_string();
    if (hold) hold_go = 1'b1;
    wait_idle();
  endtask

  initial begin
    rst_n                = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.max_codepoint = MAX_CP_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed strings at the reset limit
    idle_on = 1'b1;
    str_bytes = '{8'h00};        queue_string();
    str_bytes = '{8'h7F};        queue_string();
    add_char(21'h41, 1);
    add_char(21'h7FF, 2);
    add_char(21'hFFFF, 3);
    add_char(21'h10FFFF, 4);     queue_string();
    add_char(21'h110000, 4);     queue_string();
    str_bytes = '{8'h80, 8'h41}; queue_string();
    str_bytes = '{8'hFF};        queue_string();
    str_bytes = '{8'hC3, 8'h41}; queue_string();
    str_bytes = '{8'hE2, 8'h82}; queue_string();
    str_bytes = '{8'hF0};        queue_string();
    wait_idle();

    run_phase(21'h1FFFFF, 1'b1, 120, 1'b0);
    run_phase(21'h000000, 1'b1, 60, 1'b0);
    run_phase(21'h10FFFF, 1'b0, 120, 1'b1);
    run_phase(21'h00007F, 1'b1, 60, 1'b0);
    run_phase(cp_t'($urandom), 1'b1, 80, 1'b0);
    run_phase(21'h0007FF, 1'b1, 60, 1'b0);

    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
